@@ sv/tlc_pkg.sv @@
// types and constants shared by the traffic light controller modules
// no dependencies
`default_nettype none

package tlc_pkg;

  localparam int unsigned CFG_W       = 14;
  localparam int unsigned DUR_W       = CFG_W + 1;
  localparam int unsigned SPEED_STEPS = 3;

  typedef enum logic [2:0] {
    ST_GREEN       = 3'd0,
    ST_GREEN_YEL   = 3'd1,
    ST_RED         = 3'd2,
    ST_NIGHT_YEL   = 3'd3,
    ST_NIGHT_OFF   = 3'd4,
    ST_ALARM_RED   = 3'd5,
    ST_ALARM_OFF   = 3'd6
  } light_t;

  typedef enum logic [1:0] {
    SPD_DOUBLE = 2'd0,
    SPD_NORMAL = 2'd1,
    SPD_HALF   = 2'd2,
    SPD_UNUSED = 2'd3
  } speed_t;

  typedef enum logic [1:0] {
    CFG_GREEN      = 2'd0,
    CFG_TRANSITION = 2'd1,
    CFG_RED        = 2'd2,
    CFG_BLINK      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] green_ms;
    logic [CFG_W-1:0] transition_ms;
    logic [CFG_W-1:0] red_ms;
    logic [CFG_W-1:0] blink_ms;
  } tlc_cfg_t;

  typedef struct packed {
    light_t light;
    speed_t speed;
    logic   armed;
  } tlc_state_t;

  typedef struct packed {
    logic green;
    logic yellow;
    logic red;
  } tlc_lamps_t;

endpackage

`default_nettype wire

@@ sv/traffic_light_controller_core.sv @@
// top level of the traffic light controller: input register, step logic, result register
// depends on tlc_pkg and tlc_step
`default_nettype none

// Seven-state traffic light controller (day, night blink, alarm blink) with a
// shared one-shot millisecond timer and a three-step speed index. Each input
// beat is one controller call and yields exactly one result beat. A beat is
// captured in an input register, the next state, lamps and timer update are
// computed combinationally from that register and the controller state, and the
// result lands in an output register; one beat is accepted every cycle while the
// result side keeps taking beats. The state update (state, speed index and timer
// start) is registered with each accepted beat, so consecutive beats can follow
// each other directly. Durations are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while idle, as the block itself does not enforce it.
module traffic_light_controller_core
  import tlc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_mode_button,
  input  wire logic                  in_speed_button,
  input  wire logic [TIME_WIDTH-1:0] in_now_ms,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_led_green,
  output logic                       out_led_yellow,
  output logic                       out_led_red,
  output logic [2:0]                 out_next_state,
  output logic [1:0]                 out_speed_level
);

  tlc_cfg_t              cfg_r;

  logic                  in_vld_r;
  logic                  in_mode_r;
  logic                  in_speed_r;
  logic [TIME_WIDTH-1:0] in_now_r;

  tlc_state_t            st_r;
  tlc_state_t            st_nxt;
  logic [TIME_WIDTH-1:0] start_r;
  logic [TIME_WIDTH-1:0] start_nxt;
  tlc_lamps_t            lamps;

  logic                  out_vld_r;
  tlc_lamps_t            lamps_r;
  logic [2:0]            next_state_r;
  logic [1:0]            speed_level_r;

  logic                  out_free;
  logic                  fire;

  assign out_free = !out_vld_r || out_ready;
  assign fire     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_ms      <= CFG_W'(3000);
      cfg_r.transition_ms <= CFG_W'(500);
      cfg_r.red_ms        <= CFG_W'(2000);
      cfg_r.blink_ms      <= CFG_W'(500);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GREEN:      cfg_r.green_ms      <= cfg_wdata;
        CFG_TRANSITION: cfg_r.transition_ms <= cfg_wdata;
        CFG_RED:        cfg_r.red_ms        <= cfg_wdata;
        CFG_BLINK:      cfg_r.blink_ms      <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode_r  <= in_mode_button;
      in_speed_r <= in_speed_button;
      in_now_r   <= in_now_ms;
    end
  end

  tlc_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cfg          (cfg_r),
    .cur          (st_r),
    .cur_start    (start_r),
    .mode_button  (in_mode_r),
    .speed_button (in_speed_r),
    .now_ms       (in_now_r),
    .nxt          (st_nxt),
    .nxt_start    (start_nxt),
    .lamps        (lamps)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.light <= ST_GREEN;
      st_r.speed <= SPD_DOUBLE;
      st_r.armed <= 1'b1;
      start_r    <= '0;
    end else if (fire) begin
      st_r    <= st_nxt;
      start_r <= start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lamps_r       <= lamps;
      next_state_r  <= st_nxt.light;
      speed_level_r <= st_nxt.speed;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_led_green   = lamps_r.green;
  assign out_led_yellow  = lamps_r.yellow;
  assign out_led_red     = lamps_r.red;
  assign out_next_state  = next_state_r;
  assign out_speed_level = speed_level_r;

endmodule

`default_nettype wire

@@ sv/tlc_step.sv @@
// next-state, lamp and shared timer logic for one controller beat
// depends on tlc_pkg
`default_nettype none

module tlc_step
  import tlc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  tlc_cfg_t              cfg,
  input  tlc_state_t            cur,
  input  logic [TIME_WIDTH-1:0] cur_start,
  input  logic                  mode_button,
  input  logic                  speed_button,
  input  logic [TIME_WIDTH-1:0] now_ms,
  output tlc_state_t            nxt,
  output logic [TIME_WIDTH-1:0] nxt_start,
  output tlc_lamps_t            lamps
);

  speed_t                spd;
  logic [CFG_W-1:0]      dur_base;
  logic [DUR_W-1:0]      dur;
  logic [TIME_WIDTH-1:0] start_eff;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired;
  logic                  use_timer;
  light_t                light_nxt;

  // speed index advances first, the new value scales this beat's duration
  always_comb begin
    spd = cur.speed;
    if (speed_button) begin
      unique case (cur.speed)
        SPD_NORMAL: spd = SPD_HALF;
        SPD_HALF:   spd = SPD_DOUBLE;
        default:    spd = SPD_NORMAL;
      endcase
    end else if (cur.speed == SPD_UNUSED) begin
      spd = SPD_DOUBLE;
    end
  end

  always_comb begin
    unique case (cur.light)
      ST_GREEN:     dur_base = cfg.green_ms;
      ST_GREEN_YEL: dur_base = cfg.transition_ms;
      ST_RED:       dur_base = cfg.red_ms;
      default:      dur_base = cfg.blink_ms;
    endcase
    unique case (spd)
      SPD_NORMAL: dur = {1'b0, dur_base};
      SPD_HALF:   dur = {2'b00, dur_base[CFG_W-1:1]};
      default:    dur = {dur_base, 1'b0};
    endcase
  end

  always_comb begin
    start_eff = cur.armed ? now_ms : cur_start;
    elapsed   = now_ms - start_eff;
    expired   = elapsed > {{(TIME_WIDTH-DUR_W){1'b0}}, dur};
  end

  always_comb begin
    lamps     = '0;
    light_nxt = ST_GREEN;
    use_timer = !mode_button;
    unique case (cur.light)
      ST_GREEN: begin
        lamps.green = 1'b1;
        light_nxt   = mode_button ? ST_NIGHT_YEL : (expired ? ST_GREEN_YEL : ST_GREEN);
      end
      ST_GREEN_YEL: begin
        lamps.green  = 1'b1;
        lamps.yellow = 1'b1;
        light_nxt    = mode_button ? ST_NIGHT_YEL : (expired ? ST_RED : ST_GREEN_YEL);
      end
      ST_RED: begin
        lamps.red = 1'b1;
        light_nxt = mode_button ? ST_NIGHT_YEL : (expired ? ST_GREEN : ST_RED);
      end
      ST_NIGHT_YEL: begin
        lamps.yellow = 1'b1;
        light_nxt    = mode_button ? ST_ALARM_RED : (expired ? ST_NIGHT_OFF : ST_NIGHT_YEL);
      end
      ST_NIGHT_OFF: begin
        light_nxt = mode_button ? ST_ALARM_RED : (expired ? ST_NIGHT_YEL : ST_NIGHT_OFF);
      end
      ST_ALARM_RED: begin
        lamps.red = 1'b1;
        light_nxt = mode_button ? ST_GREEN : (expired ? ST_ALARM_OFF : ST_ALARM_RED);
      end
      ST_ALARM_OFF: begin
        light_nxt = mode_button ? ST_GREEN : (expired ? ST_ALARM_RED : ST_ALARM_OFF);
      end
      default: begin
        // unused code: green lamp, back to green, timer untouched
        lamps.green = 1'b1;
        light_nxt   = ST_GREEN;
        use_timer   = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt.light = light_nxt;
    nxt.speed = spd;
    nxt.armed = use_timer ? expired : cur.armed;
    nxt_start = use_timer ? start_eff : cur_start;
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for traffic_light_controller_core: directed and random controller calls
// predicts lamps, next state and speed level per call; depends on tlc_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
  import tlc_pkg::*;

  localparam logic [CFG_W-1:0] DUR_MAX   = '1;
  localparam int unsigned      HOLD_LEN  = 300;
  localparam int unsigned      PHASES    = 8;
  localparam int unsigned      PHASE_LEN = 195;

  typedef struct packed {
    tlc_lamps_t lamps;
    light_t     state_nx;
    speed_t     speed;
  } step_out_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode_button;
  logic        in_speed_button;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  logic        out_led_green;
  logic        out_led_yellow;
  logic        out_led_red;
  logic [2:0]  out_next_state;
  logic [1:0]  out_speed_level;

  // controller state as predicted
  light_t           ctl_light;
  speed_t           ctl_speed;
  logic [31:0]      ctl_t0;
  logic             ctl_armed;
  logic [CFG_W-1:0] dur_green;
  logic [CFG_W-1:0] dur_transition;
  logic [CFG_W-1:0] dur_red;
  logic [CFG_W-1:0] dur_blink;

  step_out_t   step_out_q[$];
  logic [31:0] now_cursor;
  bit          src_calm;
  bit          sink_calm;
  bit          hold_req;
  int          errors;
  int          calls_sent;
  int          results_seen;
  int          cfg_sets;

  traffic_light_controller_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode_button  (in_mode_button),
    .in_speed_button (in_speed_button),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_green   (out_led_green),
    .out_led_yellow  (out_led_yellow),
    .out_led_red     (out_led_red),
    .out_next_state  (out_next_state),
    .out_speed_level (out_speed_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // scaled duration of the current state at the current speed
  function automatic logic [DUR_W-1:0] current_limit();
    logic [CFG_W-1:0] base;
    case (ctl_light)
      ST_GREEN:     base = dur_green;
      ST_GREEN_YEL: base = dur_transition;
      ST_RED:       base = dur_red;
      default:      base = dur_blink;
    endcase
    case (ctl_speed)
      SPD_NORMAL: current_limit = {1'b0, base};
      SPD_HALF:   current_limit = {2'b00, base[CFG_W-1:1]};
      default:    current_limit = {base, 1'b0};
    endcase
  endfunction

  function automatic step_out_t predict_step(input logic mode, input logic spd,
                                             input logic [31:0] now);
    step_out_t   o;
    logic        fire;
    logic [31:0] elapsed;
    logic [31:0] lim;
    light_t      nxt;
    if (spd) begin
      case (ctl_speed)
        SPD_NORMAL: ctl_speed = SPD_HALF;
        SPD_HALF:   ctl_speed = SPD_DOUBLE;
        default:    ctl_speed = SPD_NORMAL;
      endcase
    end else if (ctl_speed == SPD_UNUSED) begin
      ctl_speed = SPD_DOUBLE;
    end
    o.lamps = '0;
    case (ctl_light)
      ST_GREEN:     o.lamps.green = 1'b1;
      ST_GREEN_YEL: begin
        o.lamps.green  = 1'b1;
        o.lamps.yellow = 1'b1;
      end
      ST_RED:       o.lamps.red = 1'b1;
      ST_NIGHT_YEL: o.lamps.yellow = 1'b1;
      ST_NIGHT_OFF: o.lamps = '0;
      ST_ALARM_RED: o.lamps.red = 1'b1;
      ST_ALARM_OFF: o.lamps = '0;
      default:      o.lamps.green = 1'b1;
    endcase
    fire = 1'b0;
    if (!mode && ctl_light <= ST_ALARM_OFF) begin
      if (ctl_armed) begin
        ctl_t0    = now;
        ctl_armed = 1'b0;
      end
      elapsed = now - ctl_t0;
      lim     = {{(32-DUR_W){1'b0}}, current_limit()};
      if (elapsed > lim) begin
        fire      = 1'b1;
        ctl_armed = 1'b1;
      end
    end
    case (ctl_light)
      ST_GREEN:     nxt = mode ? ST_NIGHT_YEL : (fire ? ST_GREEN_YEL : ST_GREEN);
      ST_GREEN_YEL: nxt = mode ? ST_NIGHT_YEL : (fire ? ST_RED : ST_GREEN_YEL);
      ST_RED:       nxt = mode ? ST_NIGHT_YEL : (fire ? ST_GREEN : ST_RED);
      ST_NIGHT_YEL: nxt = mode ? ST_ALARM_RED : (fire ? ST_NIGHT_OFF : ST_NIGHT_YEL);
      ST_NIGHT_OFF: nxt = mode ? ST_ALARM_RED : (fire ? ST_NIGHT_YEL : ST_NIGHT_OFF);
      ST_ALARM_RED: nxt = mode ? ST_GREEN : (fire ? ST_ALARM_OFF : ST_ALARM_RED);
      ST_ALARM_OFF: nxt = mode ? ST_GREEN : (fire ? ST_ALARM_RED : ST_ALARM_OFF);
      default:      nxt = ST_GREEN;
    endcase
    ctl_light  = nxt;
    o.state_nx = nxt;
    o.speed    = ctl_speed;
    return o;
  endfunction

  function automatic logic [CFG_W-1:0] pick_duration();
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom_range(0, DUR_MAX));
    return CFG_W'($urandom_range(1, 300));
  endfunction

  task automatic send_call(input logic mode, input logic spd, input logic [31:0] now);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode_button  <= mode;
    in_speed_button <= spd;
    in_now_ms       <= now;
    step_out_q.push_back(predict_step(mode, spd, now));
    calls_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // time steps are mostly near the active duration so the timer keeps expiring
  task automatic send_random_call();
    logic [31:0] lim;
    lim = {{(32-DUR_W){1'b0}}, current_limit()};
    case ($urandom_range(0, 9))
      0:       now_cursor = $urandom;
      1:       now_cursor = now_cursor;
      2, 3:    now_cursor = now_cursor + $urandom_range(0, 3);
      4:       now_cursor = now_cursor + $urandom_range(0, lim + 4);
      default: now_cursor = now_cursor + lim + $urandom_range(0, 2) - 1;
    endcase
    send_call($urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0, now_cursor);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (step_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_durations(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] t,
                                 input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] b);
    cfg_idx_t         order[4];
    logic [CFG_W-1:0] vals[4];
    order = '{CFG_GREEN, CFG_TRANSITION, CFG_RED, CFG_BLINK};
    vals  = '{g, t, r, b};
    settle_block();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we         <= 1'b0;
    dur_green      = g;
    dur_transition = t;
    dur_red        = r;
    dur_blink      = b;
    cfg_sets++;
  endtask

  // reset durations at double length: green lasts 6000 ms, expiry needs strictly more
  task automatic test_timer_boundary();
    send_call(1'b0, 1'b0, 32'd100);
    send_call(1'b0, 1'b0, 32'd6100);
    send_call(1'b0, 1'b0, 32'd6101);
    send_call(1'b0, 1'b0, 32'd6101);
    now_cursor = 32'd6101;
  endtask

  task automatic test_speed_steps();
    repeat (4) begin
      now_cursor = now_cursor + 1;
      send_call(1'b0, 1'b1, now_cursor);
    end
    now_cursor = now_cursor + 1;
    send_call(1'b1, 1'b1, now_cursor);
  endtask

  // zero durations expire on any nonzero elapsed time
  task automatic test_zero_durations();
    write_durations('0, '0, '0, '0);
    for (int i = 0; i < 10; i++) begin
      now_cursor = now_cursor + 1;
      send_call(i % 4 == 2, 1'b0, now_cursor);
    end
  endtask

  task automatic test_time_extremes();
    write_durations(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
    send_call(1'b0, 1'b0, 32'hFFFF_FF00);
    send_call(1'b0, 1'b0, 32'hFFFF_FF00 + current_limit());
    send_call(1'b0, 1'b0, 32'hFFFF_FF01 + current_limit());
    send_call(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_call(1'b0, 1'b0, 32'h0000_0000);
    now_cursor = 32'h0000_0000;
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_durations(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
        1:       write_durations(CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
        2:       write_durations('0, '0, '0, '0);
        default: write_durations(pick_duration(), pick_duration(), pick_duration(),
                                 pick_duration());
      endcase
      src_calm  = (phase % 4 == 1);
      sink_calm = (phase % 4 == 2);
      repeat (PHASE_LEN) send_random_call();
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  // result side stalls long while calls keep coming, so the input must back up
  task automatic test_backpressure();
    write_durations(pick_duration(), pick_duration(), pick_duration(), pick_duration());
    src_calm = 1'b1;
    hold_req = 1'b1;
    repeat (60) send_random_call();
    src_calm = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    step_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (step_out_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got state %0d", $time,
                 out_next_state);
      end else begin
        want = step_out_q.pop_front();
        compare_field("led_green", {2'b00, want.lamps.green}, {2'b00, out_led_green});
        compare_field("led_yellow", {2'b00, want.lamps.yellow}, {2'b00, out_led_yellow});
        compare_field("led_red", {2'b00, want.lamps.red}, {2'b00, out_led_red});
        compare_field("next_state", want.state_nx, out_next_state);
        compare_field("speed_level", {1'b0, want.speed}, {1'b0, out_speed_level});
        results_seen++;
      end
    end
  end

  initial begin : result_sink
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (out_valid && out_ready) wait_left = sink_calm ? 0 : $urandom_range(0, 16);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_GREEN;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_mode_button  <= 1'b0;
    in_speed_button <= 1'b0;
    in_now_ms       <= '0;
    ctl_light      = ST_GREEN;
    ctl_speed      = SPD_DOUBLE;
    ctl_t0         = '0;
    ctl_armed      = 1'b1;
    dur_green      = CFG_W'(3000);
    dur_transition = CFG_W'(500);
    dur_red        = CFG_W'(2000);
    dur_blink      = CFG_W'(500);
    now_cursor     = '0;
    src_calm       = 1'b0;
    sink_calm      = 1'b0;
    hold_req       = 1'b0;
    errors         = 0;
    calls_sent     = 0;
    results_seen   = 0;
    cfg_sets       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_timer_boundary();
    test_speed_steps();
    test_zero_durations();
    test_time_extremes();
    test_random_phases();
    test_backpressure();
    settle_block();
    repeat (8) @(posedge clk);
    if (step_out_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, step_out_q.size());
    end
    $display("ran %0d controller calls over %0d duration settings, %0d result beats checked",
             calls_sent, cfg_sets, results_seen);
    $display("covered timer boundary, speed cycling, mode changes, time wrap, stalls");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
